// ===== src/uep_pkg.sv =====
// Shared types, constants and character functions for the UTF-8 path escaper.
package uep_pkg;

  // One unit of work handed from the front to the back.
  typedef enum logic [1:0] {
    TK_LIT,  // the byte itself
    TK_ESC,  // backslash, then the byte
    TK_HEX,  // \xHH of the byte
    TK_UNI   // \u00HH of the byte
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  val;
    logic        last;
  } token_t;

  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrLowX   = 8'h78;
  localparam logic [7:0] ChrLowU   = 8'h75;
  localparam logic [7:0] ChrLowN   = 8'h6E;
  localparam logic [7:0] ChrLowR   = 8'h72;
  localparam logic [7:0] ChrLowT   = 8'h74;
  localparam logic [7:0] ChrNl     = 8'h0A;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrDel    = 8'h7F;
  localparam logic [7:0] ChrUpperA = 8'h41;

  localparam logic [7:0]  Lead2Lo  = 8'hC2;
  localparam logic [7:0]  Lead2Hi  = 8'hDF;
  localparam logic [7:0]  Lead4Lo  = 8'hF0;
  localparam logic [7:0]  Lead4Hi  = 8'hF4;
  localparam logic [20:0] CpMin2   = 21'h00080;
  localparam logic [20:0] CpMin3   = 21'h00800;
  localparam logic [20:0] CpMin4   = 21'h10000;
  localparam logic [20:0] CpMax    = 21'h10FFFF;
  localparam logic [20:0] SurrLo   = 21'h0D800;
  localparam logic [20:0] SurrHi   = 21'h0DFFF;
  localparam logic [20:0] C1Lo     = 21'h00080;
  localparam logic [20:0] C1Hi     = 21'h0009F;

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) begin
      return ChrZero + {4'h0, d};
    end
    return ChrUpperA + {4'h0, d} - 8'd10;
  endfunction

  // Position of the final character of a token.
  function automatic logic [2:0] tok_last_pos(tok_kind_e k);
    logic [2:0] p;
    unique case (k)
      TK_LIT:  p = 3'd0;
      TK_ESC:  p = 3'd1;
      TK_HEX:  p = 3'd3;
      TK_UNI:  p = 3'd5;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] tok_char(tok_kind_e k, logic [7:0] v, logic [2:0] pos);
    logic [7:0] c;
    c = v;
    unique case (k)
      TK_LIT: c = v;
      TK_ESC: c = (pos == 3'd0) ? ChrBslash : v;
      TK_HEX: begin
        unique case (pos)
          3'd0:    c = ChrBslash;
          3'd1:    c = ChrLowX;
          3'd2:    c = hex_char(v[7:4]);
          default: c = hex_char(v[3:0]);
        endcase
      end
      TK_UNI: begin
        unique case (pos)
          3'd0:      c = ChrBslash;
          3'd1:      c = ChrLowU;
          3'd2, 3'd3: c = ChrZero;
          3'd4:      c = hex_char(v[7:4]);
          default:   c = hex_char(v[3:0]);
        endcase
      end
      default: c = v;
    endcase
    return c;
  endfunction

  // Token for a byte seen with no sequence open; only meaningful for non-lead bytes.
  function automatic token_t idle_token(logic [7:0] b);
    token_t t;
    t.val  = b;
    t.last = 1'b0;
    t.kind = TK_HEX;
    priority if (b == ChrBslash) begin
      t.kind = TK_ESC;
    end else if (b == ChrNl) begin
      t.kind = TK_ESC;
      t.val  = ChrLowN;
    end else if (b == ChrCr) begin
      t.kind = TK_ESC;
      t.val  = ChrLowR;
    end else if (b == ChrTab) begin
      t.kind = TK_ESC;
      t.val  = ChrLowT;
    end else if (b < ChrSpace || b == ChrDel || b[7]) begin
      t.kind = TK_HEX;
    end else begin
      t.kind = TK_LIT;
    end
    return t;
  endfunction

endpackage

// ===== src/uep_fifo.sv =====
// Small token queue between the decoder front and the expander back.
module uep_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  uep_pkg::token_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output uep_pkg::token_t pop_data_o
);
  import uep_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("token queue count exceeds depth");

endmodule

// ===== src/uep_front.sv =====
// Decoder front: gathers UTF-8 sequences and turns each byte into up to four tokens.
module uep_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output uep_pkg::token_t tok_data_o
);
  import uep_pkg::*;

  logic [7:0]  pend_q [3];
  logic [1:0]  pend_cnt_q, pend_cnt_d;
  logic [2:0]  exp_q, exp_d;
  logic [20:0] cp_q, cp_d;
  logic        pend_we;
  logic [1:0]  pend_widx;

  token_t      st_q [4];
  logic [2:0]  st_cnt_q;

  token_t      tok_list [4];
  token_t      tail_tok;
  logic        tail_v;
  logic [1:0]  n_held;
  tok_kind_e   held_kind;
  logic [2:0]  total;
  logic [1:0]  tot_m1;

  logic        accept, push;
  logic        is_cont, lead2, lead3, lead4, is_lead, seq_bad, is_c1;
  logic [20:0] new_cp, cp_min;

  assign push        = (st_cnt_q != 3'd0) && tok_ready_i;
  assign in_ready_o  = (st_cnt_q == 3'd0) || (st_cnt_q == 3'd1 && push);
  assign accept      = in_valid_i && in_ready_o;
  assign tok_valid_o = (st_cnt_q != 3'd0);
  assign tok_data_o  = st_q[0];

  assign is_cont = (in_byte_i[7:6] == 2'b10);
  assign lead2   = (in_byte_i >= Lead2Lo) && (in_byte_i <= Lead2Hi);
  assign lead3   = (in_byte_i[7:4] == 4'hE);
  assign lead4   = (in_byte_i >= Lead4Lo) && (in_byte_i <= Lead4Hi);
  assign is_lead = lead2 || lead3 || lead4;
  assign new_cp  = {cp_q[14:0], in_byte_i[5:0]};

  always_comb begin
    unique case (exp_q)
      3'd2:    cp_min = CpMin2;
      3'd3:    cp_min = CpMin3;
      default: cp_min = CpMin4;
    endcase
  end

  assign seq_bad = (new_cp < cp_min) || (new_cp > CpMax) ||
                   ((new_cp >= SurrLo) && (new_cp <= SurrHi));
  assign is_c1   = (new_cp >= C1Lo) && (new_cp <= C1Hi);

  // Output of one byte is a run of held bytes of one kind, then at most one tail token.
  always_comb begin
    pend_cnt_d = pend_cnt_q;
    exp_d      = exp_q;
    cp_d       = cp_q;
    pend_we    = 1'b0;
    pend_widx  = pend_cnt_q;
    n_held     = 2'd0;
    held_kind  = TK_HEX;
    tail_v     = 1'b1;
    tail_tok   = '{kind: TK_HEX, val: in_byte_i, last: 1'b0};

    if (pend_cnt_q == 2'd0 || !is_cont) begin
      n_held     = pend_cnt_q;
      pend_cnt_d = 2'd0;
      exp_d      = 3'd0;
      cp_d       = '0;
      if (is_lead) begin
        if (!in_last_i) begin
          tail_v     = 1'b0;
          pend_we    = 1'b1;
          pend_widx  = 2'd0;
          pend_cnt_d = 2'd1;
          priority if (lead2) begin
            exp_d = 3'd2;
            cp_d  = {16'h0, in_byte_i[4:0]};
          end else if (lead3) begin
            exp_d = 3'd3;
            cp_d  = {17'h0, in_byte_i[3:0]};
          end else begin
            exp_d = 3'd4;
            cp_d  = {18'h0, in_byte_i[2:0]};
          end
        end
      end else begin
        tail_tok = idle_token(in_byte_i);
      end
    end else if (({1'b0, pend_cnt_q} + 3'd1) < exp_q) begin
      if (in_last_i) begin
        // Sequence cut short by the end of the path.
        n_held     = pend_cnt_q;
        pend_cnt_d = 2'd0;
        exp_d      = 3'd0;
        cp_d       = '0;
      end else begin
        tail_v     = 1'b0;
        pend_we    = 1'b1;
        pend_cnt_d = pend_cnt_q + 2'd1;
        cp_d       = new_cp;
      end
    end else begin
      pend_cnt_d = 2'd0;
      exp_d      = 3'd0;
      cp_d       = '0;
      priority if (seq_bad) begin
        n_held = pend_cnt_q;
      end else if (is_c1) begin
        tail_tok = '{kind: TK_UNI, val: new_cp[7:0], last: 1'b0};
      end else begin
        n_held    = pend_cnt_q;
        held_kind = TK_LIT;
        tail_tok  = '{kind: TK_LIT, val: in_byte_i, last: 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tok_list[i] = '{kind: held_kind, val: pend_q[i], last: 1'b0};
    end
    tok_list[3] = tail_tok;
    if (tail_v) begin
      tok_list[n_held] = tail_tok;
    end
    total  = {1'b0, n_held} + {2'b00, tail_v};
    tot_m1 = 2'(total - 3'd1);
    if (in_last_i && total != 3'd0) begin
      tok_list[tot_m1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pend_we) begin
      pend_q[pend_widx] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= tok_list;
    end else if (push) begin
      for (int i = 0; i < 3; i++) begin
        st_q[i] <= st_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
      exp_q      <= 3'd0;
      cp_q       <= '0;
      st_cnt_q   <= 3'd0;
    end else begin
      if (accept) begin
        pend_cnt_q <= pend_cnt_d;
        exp_q      <= exp_d;
        cp_q       <= cp_d;
        st_cnt_q   <= total;
      end else if (push) begin
        st_cnt_q <= st_cnt_q - 3'd1;
      end
    end
  end

  a_stage_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_cnt_q <= 3'd4)
    else $error("token stage holds more than four tokens");

  a_pend_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q != 2'd0) |-> ({1'b0, pend_cnt_q} < exp_q))
    else $error("held byte count reached sequence length");

endmodule

// ===== src/uep_back.sv =====
// Expander back: turns each token into its characters, one per cycle unless the output stalls.
module uep_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  output logic            tok_ready_o,
  input  uep_pkg::token_t tok_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);
  import uep_pkg::*;

  token_t      tok_q;
  logic        busy_q;
  logic [2:0]  pos_q;
  logic        out_v_q, out_last_q;
  logic [7:0]  out_char_q;

  logic        load, is_end, pop;

  assign load        = busy_q && (!out_v_q || out_ready_i);
  assign is_end      = (pos_q == tok_last_pos(tok_q.kind));
  assign pop         = tok_valid_i && (!busy_q || (load && is_end));
  assign tok_ready_o = !busy_q || (load && is_end);

  assign out_valid_o = out_v_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      tok_q <= tok_data_i;
    end
    if (load) begin
      out_char_q <= tok_char(tok_q.kind, tok_q.val, pos_q);
      out_last_q <= is_end && tok_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pos_q   <= 3'd0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (pop) begin
        busy_q <= 1'b1;
        pos_q  <= 3'd0;
      end else if (load) begin
        if (is_end) begin
          busy_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= tok_last_pos(tok_q.kind)))
    else $error("character position past end of token");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_char_q) && $stable(out_last_q)))
    else $error("output beat changed while stalled");

endmodule

// ===== src/utf8_path_escaper.sv =====
// Top level of the UTF-8 path escaper: decoder front, token queue, expander back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_byte_i, in_last_i
//   out      output     out_valid_o/out_ready_i out_char_o, out_last_o
//
// The front takes a byte and pushes its tokens (zero to four) one per cycle while the
// queue has room; it takes the next byte in the same cycle as it pushes the last one.
// The back emits one character per cycle while out_ready_i is high, 1, 2, 4 or 6 per
// token, so a byte yields up to 16 characters and the output sets the sustained rate.
// Reset clears all control state at once. The queue holds FifoDepth tokens; a short stall
// on either side is absorbed, a long output stall fills the queue and then holds the input.
module utf8_path_escaper #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);
  import uep_pkg::*;

  token_t f_data, b_data;
  logic   f_valid, f_ready, b_valid, b_ready;

  uep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .tok_valid_o (f_valid),
    .tok_ready_i (f_ready),
    .tok_data_o  (f_data)
  );

  uep_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  uep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (b_valid),
    .tok_ready_o (b_ready),
    .tok_data_i  (b_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== tb/utf8_path_escaper_tb.sv =====
// Self-checking testbench for utf8_path_escaper: random and directed paths, scoreboard.
`timescale 1ns / 1ps

module utf8_path_escaper_tb;
  import uep_pkg::*;

  localparam int StuckLimit = 1000;
  localparam int HoldOff    = 150;
  localparam int MaxChars   = 16;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_char_o;
  logic       out_last_o;

  utf8_path_escaper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: the open UTF-8 sequence.
  logic [7:0]  held [3];
  logic [1:0]  held_cnt  = 2'd0;
  logic [2:0]  seq_len   = 3'd0;
  logic [20:0] code_pt   = 21'd0;

  beat_t path_bytes_q [$];
  beat_t line_chars_q [$];
  beat_t escaped_q    [$];
  logic [7:0] path_buf [$];

  int    errors     = 0;
  int    in_beats   = 0;
  int    out_beats  = 0;
  int    stuck      = 0;
  int    rand_bytes = 0;
  beat_t want;

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h41 + {4'h0, n} - 8'd10;
  endfunction

  function void put(logic [7:0] c);
    line_chars_q.insert(line_chars_q.size(), '{val: c, last: 1'b0});
  endfunction

  function void put_hex(logic [7:0] b);
    put("\\");
    put("x");
    put(hex_digit(b[7:4]));
    put(hex_digit(b[3:0]));
  endfunction

  function void clear_seq();
    held_cnt = 2'd0;
    seq_len  = 3'd0;
    code_pt  = 21'd0;
  endfunction

  // A byte seen with no sequence open.
  function void plain_byte(logic [7:0] b);
    if (!b[7]) begin
      if (b == ChrBslash) begin
        put("\\");
        put("\\");
      end else if (b == ChrNl) begin
        put("\\");
        put("n");
      end else if (b == ChrCr) begin
        put("\\");
        put("r");
      end else if (b == ChrTab) begin
        put("\\");
        put("t");
      end else if (b < ChrSpace || b == ChrDel) begin
        put_hex(b);
      end else begin
        put(b);
      end
      return;
    end
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      seq_len = 3'd2;
      code_pt = {16'd0, b[4:0]};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      seq_len = 3'd3;
      code_pt = {17'd0, b[3:0]};
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      seq_len = 3'd4;
      code_pt = {18'd0, b[2:0]};
    end else begin
      put_hex(b);
      return;
    end
    held[0]  = b;
    held_cnt = 2'd1;
  endfunction

  // The lead byte is shown as \xHH and the held continuations are replayed.
  function void drop_seq();
    int k;
    logic [7:0] h1;
    logic [7:0] h2;
    k  = held_cnt;
    h1 = held[1];
    h2 = held[2];
    if (k == 0) return;
    put_hex(held[0]);
    clear_seq();
    if (k > 1) plain_byte(h1);
    if (k > 2) plain_byte(h2);
  endfunction

  function void take_byte(logic [7:0] b);
    logic [20:0] cp_min;
    if (held_cnt == 2'd0) begin
      plain_byte(b);
      return;
    end
    if (b[7:6] != 2'b10) begin
      drop_seq();
      plain_byte(b);
      return;
    end
    code_pt = {code_pt[14:0], b[5:0]};
    if (held_cnt + 1 < seq_len && held_cnt < 3) begin
      held[held_cnt] = b;
      held_cnt = held_cnt + 2'd1;
      return;
    end
    cp_min = (seq_len == 3'd2) ? CpMin2 : (seq_len == 3'd3) ? CpMin3 : CpMin4;
    if (code_pt < cp_min || code_pt > CpMax || (code_pt >= SurrLo && code_pt <= SurrHi)) begin
      drop_seq();
      plain_byte(b);
      return;
    end
    if (code_pt >= C1Lo && code_pt <= C1Hi) begin
      put("\\");
      put("u");
      put("0");
      put("0");
      put(hex_digit(code_pt[7:4]));
      put(hex_digit(code_pt[3:0]));
    end else begin
      for (int i = 0; i < held_cnt; i++) put(held[i]);
      put(b);
    end
    clear_seq();
  endfunction

  // Works out the display characters that one accepted input beat must produce.
  function void escape_byte(logic [7:0] b, logic last);
    beat_t tail;
    line_chars_q.delete();
    take_byte(b);
    if (last) begin
      if (held_cnt != 2'd0) drop_seq();
      if (line_chars_q.size() > 0) begin
        tail = line_chars_q[line_chars_q.size() - 1];
        tail.last = 1'b1;
        line_chars_q[line_chars_q.size() - 1] = tail;
      end
    end
    for (int i = 0; i < line_chars_q.size() && i < MaxChars; i++) begin
      escaped_q.insert(escaped_q.size(), line_chars_q[i]);
    end
  endfunction

  task automatic add_path(input logic [7:0] bytes [$]);
    for (int i = 0; i < bytes.size(); i++) begin
      path_bytes_q.insert(path_bytes_q.size(),
                          '{val: bytes[i], last: (i == bytes.size() - 1)});
    end
  endtask

  function void append_byte(logic [7:0] b);
    path_buf.insert(path_buf.size(), b);
  endfunction

  function logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // One random path: mostly well-formed characters, some broken sequences and noise.
  task automatic gen_path();
    int n;
    int kind;
    int cut;
    logic [7:0] lead;
    path_buf.delete();
    n = $urandom_range(1, 6);
    for (int c = 0; c < n; c++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: append_byte(8'($urandom_range(8'h20, 8'h7E)));
        3: begin
          case ($urandom_range(0, 3))
            0:       append_byte(ChrBslash);
            1:       append_byte(ChrDel);
            default: append_byte(8'($urandom_range(0, 31)));
          endcase
        end
        4: begin
          append_byte(8'($urandom_range(Lead2Lo, Lead2Hi)));
          append_byte(cont_byte());
        end
        5: begin
          append_byte(8'($urandom_range(8'hE0, 8'hEF)));
          append_byte(cont_byte());
          append_byte(cont_byte());
        end
        6: begin
          append_byte(8'($urandom_range(Lead4Lo, Lead4Hi)));
          repeat (3) append_byte(cont_byte());
        end
        7: begin
          lead = 8'($urandom_range(Lead2Lo, Lead4Hi));
          append_byte(lead);
          cut = (lead >= Lead4Lo) ? 2 : (lead >= 8'hE0) ? 1 : 0;
          repeat ($urandom_range(0, cut)) append_byte(cont_byte());
        end
        8: append_byte(8'($urandom_range(0, 255)));
        default: begin
          append_byte(Lead2Lo);
          append_byte(8'($urandom_range(8'h80, 8'h9F)));
        end
      endcase
    end
    rand_bytes += path_buf.size();
    add_path(path_buf);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int    burst_left = 1;
  int    gap_left   = 0;
  int    in_seen    = 0;
  beat_t next_beat;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_beats != in_seen) begin
        if (in_valid_i) begin
          in_seen   = in_beats;
          next_beat = path_bytes_q.pop_front();
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (path_bytes_q.size() > 0) begin
          next_beat = path_bytes_q[0];
          in_valid_i <= 1'b1;
          in_byte_i  <= next_beat.val;
          in_last_i  <= next_beat.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating ready pattern, redrawn now and then, plus one long hold-off.
  logic [15:0] ready_pat  = 16'hFFFF;
  int          pat_cycles = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && out_beats >= 80) begin
        hold_done = 1'b1;
        hold_left = HoldOff - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_cycles == 0) begin
          pat_cycles = $urandom_range(20, 80);
          ready_pat  = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
        end
        pat_cycles--;
        out_ready_i <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  // Monitor: predicts on every input beat and checks every output beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_beats <= out_beats + 1;
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected output beat: char %h last %b", $time, out_char_o,
                   out_last_o);
          errors++;
        end else begin
          want = escaped_q.pop_front();
          if (out_char_o !== want.val) begin
            $display("%0t: out_char expected %h actual %h", $time, want.val, out_char_o);
            errors++;
          end
          if (out_last_o !== want.last) begin
            $display("%0t: out_last expected %b actual %b", $time, want.last, out_last_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_beats <= in_beats + 1;
        escape_byte(in_byte_i, in_last_i);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck == StuckLimit) begin
        $display("utf8_path_escaper_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    // Directed paths: ASCII escapes, bad leads, C1, surrogate, out of range,
    // broken and overlong sequences, and a sequence cut short by the end.
    add_path('{8'h41, ChrBslash, ChrNl, ChrCr, ChrTab, 8'h00, ChrDel, 8'hFF});
    add_path('{8'hC2, 8'h80, 8'hDF, 8'hBF});
    add_path('{8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80});
    add_path('{8'hC2, 8'h41, 8'hE0, 8'h80, 8'h80, 8'hE2, 8'h82});
    while (rand_bytes < 75) gen_path();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (path_bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("utf8_path_escaper_tb OK");
    end else begin
      $display("utf8_path_escaper_tb NOT OK");
    end
    $finish;
  end

endmodule
